FILE: rtl/rdip_pkg.sv
// Shared types and constants of the random distinct identifier picker.
package rdip_pkg;

	// Width of identifiers, slots and the share count register.
	localparam int ID_W = 8;
	// Width of the random word field on the input channel.
	localparam int RW_W = 32;
	// Width of the configuration data bus.
	localparam int APB_DW = 32;

	// Operation codes of an input transaction.
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_WORD    = 1'b1;

	// Status returned by the serial divider.
	typedef struct packed {
		logic done;
		logic accept;
	} div_status_t;

	// Request from the sequencer to the pool store.
	typedef struct packed {
		logic            clear;
		logic            rd_en;
		logic [ID_W-1:0] rd_a;
		logic [ID_W-1:0] rd_b;
		logic            wr_en;
		logic [ID_W-1:0] wr_addr;
		logic [ID_W-1:0] wr_data;
	} pool_req_t;

endpackage

FILE: rtl/rdip_if.sv
// Stream interfaces of the picker: random word requests in, settled picks out.
interface rdip_in_if;
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic [rdip_pkg::RW_W-1:0] random_word;

	modport source (output valid, output operation, output random_word, input ready);
	modport sink (input valid, input operation, input random_word, output ready);
endinterface

interface rdip_out_if;
	logic                      valid;
	logic                      ready;
	logic [rdip_pkg::ID_W-1:0] slot;
	logic [rdip_pkg::ID_W-1:0] share_number;
	logic                      last;

	modport source (output valid, output slot, output share_number, output last, input ready);
	modport sink (input valid, input slot, input share_number, input last, output ready);
endinterface

FILE: rtl/rdip_serial_div.sv
// Bit-serial restoring divider that yields word mod p and the rejection decision.
module rdip_serial_div #(
	parameter int WORD_BITS = 32,
	parameter int POS_W     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_BITS-1:0]  word,
	input  logic [POS_W-1:0]      divisor,
	output logic [POS_W-1:0]      rem,
	output rdip_pkg::div_status_t status
);
	import rdip_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] word_q;
	logic [POS_W-1:0]     div_q;
	logic [POS_W-1:0]     rem_w_q;
	logic [POS_W-1:0]     rem_m_q;
	logic                 decided_q;
	logic                 lt_q;

	logic [POS_W:0]   trial_w;
	logic [POS_W:0]   trial_m;
	logic [POS_W:0]   diff_w;
	logic [POS_W:0]   diff_m;
	logic             ge_w;
	logic             ge_m;
	logic [POS_W-1:0] rem_w_n;
	logic [POS_W-1:0] rem_m_n;

	// The word and the all-ones maximum are divided side by side. The word is
	// accepted when its quotient is below the quotient of the maximum, which
	// the quotient bits decide as they come out, most significant first.
	always_comb begin
		trial_w = {rem_w_q, word_q[WORD_BITS-1]};
		trial_m = {rem_m_q, 1'b1};
		diff_w  = trial_w - {1'b0, div_q};
		diff_m  = trial_m - {1'b0, div_q};
		ge_w    = trial_w >= {1'b0, div_q};
		ge_m    = trial_m >= {1'b0, div_q};
		rem_w_n = ge_w ? diff_w[POS_W-1:0] : trial_w[POS_W-1:0];
		rem_m_n = ge_m ? diff_m[POS_W-1:0] : trial_m[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q    <= word;
			div_q     <= divisor;
			rem_w_q   <= '0;
			rem_m_q   <= '0;
			decided_q <= 1'b0;
			lt_q      <= 1'b0;
		end else if (busy_q) begin
			word_q  <= {word_q[WORD_BITS-2:0], 1'b0};
			rem_w_q <= rem_w_n;
			rem_m_q <= rem_m_n;
			if (!decided_q && (ge_w != ge_m)) begin
				decided_q <= 1'b1;
				lt_q      <= ge_m;
			end
		end
	end

	assign rem           = rem_w_q;
	assign status.done   = done_q;
	assign status.accept = decided_q && lt_q;

endmodule

FILE: rtl/rdip_pool.sv
// Identifier pool store with two registered read ports, one write port and valid bits.
module rdip_pool #(
	parameter int ENTRIES = 255
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rdip_pkg::pool_req_t       req,
	output logic [rdip_pkg::ID_W-1:0] rd_a_data,
	output logic [rdip_pkg::ID_W-1:0] rd_b_data
);
	import rdip_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	logic [ID_W-1:0]    mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ID_W-1:0]    data_a_q;
	logic [ID_W-1:0]    data_b_q;
	logic               vld_a_q;
	logic               vld_b_q;
	logic [IDX_W-1:0]   addr_a_q;
	logic [IDX_W-1:0]   addr_b_q;

	// A cleared entry reads as its index plus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr[IDX_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_a_q <= mem[req.rd_a[IDX_W-1:0]];
			data_b_q <= mem[req.rd_b[IDX_W-1:0]];
			vld_a_q  <= valid_q[req.rd_a[IDX_W-1:0]];
			vld_b_q  <= valid_q[req.rd_b[IDX_W-1:0]];
			addr_a_q <= req.rd_a[IDX_W-1:0];
			addr_b_q <= req.rd_b[IDX_W-1:0];
		end
	end

	assign rd_a_data = vld_a_q ? data_a_q : ID_W'(addr_a_q) + ID_W'(1);
	assign rd_b_data = vld_b_q ? data_b_q : ID_W'(addr_b_q) + ID_W'(1);

endmodule

FILE: rtl/random_distinct_id_picker_core.sv
// Top level of the random distinct identifier picker: sequencer, registers and outputs.
//
// Channel    Dir  Payload                          Transaction
// pick_in    in   operation, random_word           valid && ready
// pick_out   out  slot, share_number, last         valid && ready
// apb        in   share_count at byte address 0    psel && penable && pwrite
//
// A random word is taken, then passes through the bit-serial divider, its
// status, one pool read and two pool writes for the swap. A rejected word, or
// a word after the run is complete, frees the input early.
// Reset clears all control state and the pool valid bits, so the pool reads as
// 1..ENTRIES at once; no clearing pass is needed. A stalled output holds its
// result and lets the next word be taken; only a second result waits for it.
module random_distinct_id_picker_core #(
	parameter int ENTRIES   = 255,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rdip_in_if.sink                     pick_in,
	rdip_out_if.source                  pick_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [rdip_pkg::APB_DW-1:0] pwdata,
	output logic [rdip_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import rdip_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int POS_W = $clog2(ENTRIES + 1);

	// Word index of the share count register.
	localparam logic REG_SHARE_COUNT = 1'b0;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_WNP  = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]      state_q;
	logic [POS_W-1:0] position_q;
	logic [ID_W-1:0] share_count_q;
	logic [IDX_W-1:0] r_q;
	logic            out_valid_q;
	logic [ID_W-1:0] slot_q;
	logic [ID_W-1:0] share_number_q;
	logic            last_q;

	logic                 in_fire;
	logic                 cfg_write;
	logic                 div_start;
	logic [63:0]          word_ext;
	logic [WORD_BITS-1:0] word_ld;
	logic [POS_W-1:0]     div_rem;
	div_status_t          div_status;
	pool_req_t            pool_req;
	logic [ID_W-1:0]      rd_a_data;
	logic [ID_W-1:0]      rd_b_data;
	logic [POS_W-1:0]     pos_dec;
	logic [IDX_W-1:0]     np;
	logic [ID_W-1:0]      np_id;
	logic                 emit;
	logic                 out_free;
	logic                 out_load;

	// Configuration port. Writes land in the access cycle; reads return the
	// register or zero for any other word.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_SHARE_COUNT) ? APB_DW'(share_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_count_q <= ID_W'(1);
		end else if (cfg_write && (paddr[2] == REG_SHARE_COUNT)) begin
			share_count_q <= pwdata[ID_W-1:0];
		end
	end

	// The sequencer takes one transaction at a time from its idle state.
	assign pick_in.ready = (state_q == S_IDLE);
	assign in_fire       = pick_in.valid && pick_in.ready;
	assign div_start     = in_fire && (pick_in.operation == OP_WORD) && (position_q != '0);

	// Only the low WORD_BITS bits of the random word take part.
	assign word_ext = {32'b0, pick_in.random_word};
	assign word_ld  = word_ext[WORD_BITS-1:0];

	// The slot being settled is the position after it is lowered.
	assign pos_dec = position_q - POS_W'(1);
	assign np      = pos_dec[IDX_W-1:0];
	assign np_id   = ID_W'(np);
	assign emit    = np_id < share_count_q;

	// A new result goes into the output register when it is empty or being
	// drained in the same cycle.
	assign out_free = !out_valid_q || pick_out.ready;
	assign out_load = out_free && (((state_q == S_WR) && emit) || (state_q == S_EMIT));

	rdip_serial_div #(
		.WORD_BITS (WORD_BITS),
		.POS_W     (POS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.word    (word_ld),
		.divisor (position_q),
		.rem     (div_rem),
		.status  (div_status)
	);

	// Pool access for the swap: read both entries, then write the entry taken
	// at the remainder into the settled slot and the old slot value back.
	always_comb begin
		pool_req.clear   = in_fire && (pick_in.operation == OP_RESTART);
		pool_req.rd_en   = (state_q == S_READ);
		pool_req.rd_a    = np_id;
		pool_req.rd_b    = ID_W'(r_q);
		pool_req.wr_en   = (state_q == S_WNP) || (state_q == S_WR);
		pool_req.wr_addr = (state_q == S_WNP) ? np_id : ID_W'(r_q);
		pool_req.wr_data = (state_q == S_WNP) ? rd_b_data : rd_a_data;
	end

	rdip_pool #(
		.ENTRIES (ENTRIES)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (pool_req),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			position_q  <= POS_W'(ENTRIES);
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !pick_out.ready);
			unique case (state_q)
				S_IDLE: begin
					if (pool_req.clear) begin
						position_q <= POS_W'(ENTRIES);
					end else if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_status.done) begin
						state_q <= div_status.accept ? S_READ : S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_WNP;
				end
				S_WNP: begin
					state_q <= S_WR;
				end
				S_WR: begin
					position_q <= pos_dec;
					if (!emit || out_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers. In the emit wait the position is already lowered, so
	// the slot is taken from the position itself there.
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_status.done) begin
			r_q <= div_rem[IDX_W-1:0];
		end
		if (state_q == S_WR && emit && out_free) begin
			slot_q         <= np_id;
			share_number_q <= rd_b_data;
			last_q         <= (np_id == '0);
		end else if (state_q == S_EMIT && out_free) begin
			slot_q         <= ID_W'(position_q);
			share_number_q <= rd_b_data;
			last_q         <= (position_q == '0);
		end
	end

	assign pick_out.valid        = out_valid_q;
	assign pick_out.slot         = slot_q;
	assign pick_out.share_number = share_number_q;
	assign pick_out.last         = last_q;

endmodule

FILE: verif/rdip_pick_checker.sv
// Scoreboard for the identifier picker: shadow shuffle of the pool and check of every pick.
module rdip_pick_checker
	import rdip_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	rdip_in_if                pick_in,
	rdip_out_if               pick_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	output int                failures,
	output int                pending,
	output int                picks_checked,
	output int                words_rejected,
	output int                shuffles_done
);

	localparam int          POOL_SIZE        = 255;
	localparam logic [63:0] WORD_MAX         = 64'hFFFF_FFFF;
	localparam logic [2:0]  ADDR_SHARE_COUNT = 3'd0;

	typedef struct packed {
		logic [ID_W-1:0] slot;
		logic [ID_W-1:0] share_number;
		logic            last;
	} pick_t;

	logic [ID_W-1:0] id_pool [POOL_SIZE];
	int unsigned     shuffle_pos;
	logic [ID_W-1:0] share_count;
	pick_t           expected_picks [$];

	initial begin
		failures       = 0;
		pending        = 0;
		picks_checked  = 0;
		words_rejected = 0;
		shuffles_done  = 0;
	end

	task automatic refill_pool();
		for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = ID_W'(k + 1);
		shuffle_pos = POOL_SIZE;
	endtask

	// One Fisher-Yates step: bias rejection, swap, and a pick once the
	// settled position drops below the share count.
	task automatic take_word(input logic [RW_W-1:0] word);
		logic [63:0]     bound;
		int unsigned     pick_idx;
		int unsigned     new_pos;
		logic [ID_W-1:0] held;
		if (shuffle_pos == 0) return;
		bound = WORD_MAX - (WORD_MAX % 64'(shuffle_pos));
		if (64'(word) >= bound) begin
			words_rejected++;
			return;
		end
		pick_idx = int'(64'(word) % 64'(shuffle_pos));
		new_pos = shuffle_pos - 1;
		shuffle_pos = new_pos;
		held = id_pool[new_pos];
		id_pool[new_pos] = id_pool[pick_idx];
		id_pool[pick_idx] = held;
		if (new_pos < share_count)
			expected_picks.push_back('{slot: ID_W'(new_pos), share_number: id_pool[new_pos],
				last: (new_pos == 0)});
	endtask

	task automatic check_pick();
		pick_t want;
		if (expected_picks.size() == 0) begin
			$error("unexpected pick: slot %0d share_number %0d last %0b",
				pick_out.slot, pick_out.share_number, pick_out.last);
			failures++;
			return;
		end
		want = expected_picks.pop_front();
		picks_checked++;
		if (pick_out.slot !== want.slot) begin
			$error("slot: expected %0d, got %0d", want.slot, pick_out.slot);
			failures++;
		end
		if (pick_out.share_number !== want.share_number) begin
			$error("share_number: expected %0d, got %0d", want.share_number, pick_out.share_number);
			failures++;
		end
		if (pick_out.last !== want.last) begin
			$error("last: expected %0b, got %0b", want.last, pick_out.last);
			failures++;
		end
		if (want.last) shuffles_done++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_pool();
			share_count = 8'd1;
			expected_picks.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_SHARE_COUNT)
				share_count = pwdata[ID_W-1:0];
			if (pick_out.valid && pick_out.ready) check_pick();
			if (pick_in.valid && pick_in.ready) begin
				if (pick_in.operation == OP_RESTART) refill_pool();
				else take_word(pick_in.random_word);
			end
		end
		pending = expected_picks.size();
	end

endmodule

FILE: verif/random_distinct_id_picker_core_tb.sv
// Testbench top for the identifier picker: clock, reset, stimulus and verdict.
module random_distinct_id_picker_core_tb;
	import rdip_pkg::*;

	// Generous bound on the whole run.
	localparam int CYCLE_LIMIT  = 400_000;
	// Covers one word still in flight inside the block.
	localparam int DRAIN_CYCLES = 60;
	// Length of the long output hold-off that backs the block up.
	localparam int HOLD_CYCLES  = 400;

	localparam logic [2:0] ADDR_SHARE_COUNT = 3'd0;
	// Second word address: no register lives there, writes must be ignored.
	localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int failures;
	int pending;
	int picks_checked;
	int words_rejected;
	int shuffles_done;

	int transactions_sent;
	int cycle_count;
	int stall_left;
	bit quiet;
	bit hold_request;

	rdip_in_if  pick_in ();
	rdip_out_if pick_out ();

	random_distinct_id_picker_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pick_in  (pick_in),
		.pick_out (pick_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rdip_pick_checker pick_checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.pick_in        (pick_in),
		.pick_out       (pick_out),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.failures       (failures),
		.pending        (pending),
		.picks_checked  (picks_checked),
		.words_rejected (words_rejected),
		.shuffles_done  (shuffles_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a pick that never shows up ends here.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("random_distinct_id_picker_core: mismatch");
			$finish;
		end
	end

	// Output side. Random stall bursts, none once the run
	// goes quiet, and one long hold-off on request. The hold-off is counted
	// here so the sender keeps offering words while picks pile up and the
	// block has to stall its input.
	initial begin
		pick_out.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left > 0) begin
				pick_out.ready <= 1'b0;
				stall_left--;
			end else begin
				pick_out.ready <= 1'b1;
			end
		end
	end

	// Offer one transaction, starting at a falling edge, and return at the
	// falling edge after it was taken. Valid stays high so back-to-back
	// transactions need no gap; whoever pauses next lowers it.
	task automatic send_item(input logic op, input logic [RW_W-1:0] word);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			pick_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pick_in.valid       <= 1'b1;
		pick_in.operation   <= op;
		pick_in.random_word <= word;
		do @(posedge clk); while (!pick_in.ready);
		@(negedge clk);
		transactions_sent++;
	endtask

	// Let every expected pick drain, then give a word that brings no pick
	// time to leave the block before anything else touches it.
	task automatic wait_idle();
		pick_in.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register write: setup phase, then access phase until pready.
	task automatic write_reg(input logic [2:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly uniform words. The rest sit just under the all-ones value, where
	// the bias bound rejects some of them, or are tiny, which favors the low
	// slots of the swap.
	function automatic logic [RW_W-1:0] next_word();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 300);
			1: return RW_W'($urandom_range(0, 300));
			default: return $urandom();
		endcase
	endfunction

	// One shuffle from a restart. With enough words it runs to slot 0 and
	// the surplus words are ignored. The share count can be changed once
	// part way through, and a noisy run throws in stray restarts.
	task automatic shuffle_run(input logic [ID_W-1:0] count, input int words, input int change_at,
			input logic [ID_W-1:0] later_count, input bit noisy);
		wait_idle();
		write_reg(ADDR_SHARE_COUNT, APB_DW'(count));
		send_item(OP_RESTART, $urandom());
		for (int i = 0; i < words; i++) begin
			if (i == change_at) begin
				wait_idle();
				write_reg(ADDR_SHARE_COUNT, APB_DW'(later_count));
			end
			if (noisy && $urandom_range(0, 39) == 0) send_item(OP_RESTART, $urandom());
			send_item(OP_WORD, next_word());
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		pick_in.valid       = 1'b0;
		pick_in.operation   = OP_RESTART;
		pick_in.random_word = '0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		quiet               = 1'b0;
		hold_request        = 1'b0;
		transactions_sent   = 0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. A write to the empty address must leave the share
		// count at its reset value of one.
		write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		send_item(OP_RESTART, 32'hFFFF_FFFF);
		// At position 255 the bound is the all-ones word itself, so all
		// ones is rejected; the zero word is accepted but settles slot 254,
		// which is above the share count and gives no pick.
		send_item(OP_WORD, 32'hFFFF_FFFF);
		send_item(OP_WORD, 32'h0000_0000);
		wait_idle();
		write_reg(ADDR_SHARE_COUNT, 32'd255);
		// At position 254 the bound is all ones minus 15: the two words at
		// and above it are rejected, the one just below is taken.
		send_item(OP_WORD, 32'hFFFF_FFFE);
		send_item(OP_WORD, 32'hFFFF_FFF0);
		send_item(OP_WORD, 32'hFFFF_FFEF);
		send_item(OP_WORD, 32'h0000_0001);
		send_item(OP_WORD, 32'h8000_0000);
		send_item(OP_WORD, 32'h7FFF_FFFF);
		send_item(OP_WORD, 32'hAAAA_AAAA);
		send_item(OP_WORD, 32'h5555_5555);
		send_item(OP_WORD, 32'h0000_00FD);
		send_item(OP_WORD, 32'h0000_00FE);
		// Restart in the middle of a shuffle refills the pool.
		send_item(OP_RESTART, 32'h0000_0000);
		send_item(OP_WORD, 32'h1234_5678);
		send_item(OP_WORD, 32'hDEAD_BEEF);
		// Share count zero: the shuffle moves on but nothing comes out.
		wait_idle();
		write_reg(ADDR_SHARE_COUNT, 32'd0);
		send_item(OP_WORD, 32'h0F0F_0F0F);
		send_item(OP_WORD, 32'hF0F0_F0F0);
		send_item(OP_WORD, 32'h0000_0000);

		// Every step picks: full run to slot 0 plus ignored words after it,
		// with the output held off long enough to back the block up.
		hold_request = 1'b1;
		shuffle_run(8'd255, 268, -1, 8'd0, 1'b0);

		// Share count one, raised mid-run to a random value, which may
		// already exceed the current position.
		shuffle_run(8'd1, 268, $urandom_range(150, 230), ID_W'($urandom_range(2, 254)), 1'b0);

		// Last part: no idling on either side, stray restarts in the stream.
		wait_idle();
		quiet = 1'b1;
		shuffle_run(ID_W'($urandom_range(60, 254)), 60, -1, 8'd0, 1'b1);

		wait_idle();

		$display("Run covered %0d transactions, %0d picks checked, %0d words rejected by the bias bound.",
			transactions_sent, picks_checked, words_rejected);
		$display("%0d shuffles reached slot 0; share counts 0, 1, 255, a mid-run change and random.",
			shuffles_done);
		if (pending != 0) $error("%0d expected picks never arrived", pending);
		if (failures == 0 && pending == 0) begin
			$display("random_distinct_id_picker_core: match");
		end else begin
			$display("random_distinct_id_picker_core: mismatch");
		end
		$finish;
	end

endmodule
